// ----- rtl/tsmd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsmd_pkg
// Shared types, constants and helpers of the trace sample mailbox decoder.
// ----------------------------------------------------------------------------
package tsmd_pkg;

    localparam int SAMPLE_BYTES = 13;
    localparam int BUF_BYTES    = SAMPLE_BYTES - 1;
    localparam int COUNT_W      = $clog2(SAMPLE_BYTES);
    localparam int ADDR_W       = 24;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [ADDR_W-1:0] RESYNC_ADDR_RST = 24'h7FFFE8;
    localparam logic [ADDR_W-1:0] INBOX_ADDR_RST  = 24'h7FFFE4;
    localparam logic [ADDR_W-1:0] CREDIT_ADDR_RST = 24'h7FFFE0;
    localparam logic [ADDR_W-1:0] MAGIC_TOKEN_RST = 24'h33ABB0;

    localparam logic [7:0] HDR_CREDIT  = 8'h01;
    localparam logic [7:0] MAX_PAYLOAD = 8'h04;

    typedef enum logic [1:0] {
        REG_RESYNC_ADDR = 2'd0,
        REG_INBOX_ADDR  = 2'd1,
        REG_CREDIT_ADDR = 2'd2,
        REG_MAGIC_TOKEN = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        EV_MAILBOX = 2'd0,
        EV_RESYNC  = 2'd1,
        EV_CREDIT  = 2'd2
    } t_event_kind;

    typedef logic [BUF_BYTES-1:0][7:0] t_sample;
    typedef logic [7:0][7:0]           t_word8;

    typedef struct packed {
        logic [ADDR_W-1:0] resync_addr;
        logic [ADDR_W-1:0] inbox_addr;
        logic [ADDR_W-1:0] credit_addr;
        logic [ADDR_W-1:0] magic_token;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_event_kind kind;
        logic [31:0] payload;
        logic [2:0]  count;
    } t_result;

    // Decoded byte k is raw data byte (k+6) mod 8 of the record.
    function automatic t_word8 unrotate_data(input t_sample s);
        t_word8 d;
        for (int k = 0; k < 8; k++) begin
            d[k] = s[4 + ((k + 6) % 8)];
        end
        return d;
    endfunction

    function automatic logic token_ok(input t_word8 w, input logic [ADDR_W-1:0] tok);
        return (w[1] == tok[23:16]) && (w[2] == tok[15:8]) && (w[3] == tok[7:0]) &&
               (w[0] <= MAX_PAYLOAD);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/trace_sample_mailbox_decoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trace_sample_mailbox_decoder_core
// Frame a trace byte stream into 13-byte records and report mailbox,
// resync and credit events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_byte_in) moves one trace byte
//   per transfer. Twelve bytes shift down a chain of byte cells; the
//   thirteenth (the byte-enable mask) is decoded against the chain contents
//   in the same cycle it is taken.
//   Output channel (o_out_valid / i_out_ready) carries one event per
//   transfer: o_event_kind, o_payload, o_payload_count. An event is visible
//   the cycle after the mask byte transfer.
//   Throughput: one byte per cycle unless stalled. The single output register
//   drains in the same cycle it refills, so a byte is refused only while
//   an event sits in the output register and the receiver stalls it.
//   Configuration: APB-style port, four 24-bit registers at 0x0, 0x4, 0x8,
//   0xC (resync, inbox, credit address, magic token); write only while idle.
//   Reset (i_rst_n low, synchronous): byte counter, mailbox word, output
//   valid and registers return to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module trace_sample_mailbox_decoder_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // byte stream
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_byte_in,
    // events
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_event_kind,
    output logic [31:0]                         o_payload,
    output logic [2:0]                          o_payload_count,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tsmd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [tsmd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [tsmd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import tsmd_pkg::*;

    // ---------------- configuration registers ----------------
    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       cfg_wr;
    t_reg_index cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_index'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RESYNC_ADDR: n_cfg.resync_addr = pwdata[ADDR_W-1:0];
                REG_INBOX_ADDR:  n_cfg.inbox_addr  = pwdata[ADDR_W-1:0];
                REG_CREDIT_ADDR: n_cfg.credit_addr = pwdata[ADDR_W-1:0];
                REG_MAGIC_TOKEN: n_cfg.magic_token = pwdata[ADDR_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_RESYNC_ADDR: prdata = CFG_DATA_W'(r_cfg.resync_addr);
            REG_INBOX_ADDR:  prdata = CFG_DATA_W'(r_cfg.inbox_addr);
            REG_CREDIT_ADDR: prdata = CFG_DATA_W'(r_cfg.credit_addr);
            REG_MAGIC_TOKEN: prdata = CFG_DATA_W'(r_cfg.magic_token);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resync_addr <= RESYNC_ADDR_RST;
            r_cfg.inbox_addr  <= INBOX_ADDR_RST;
            r_cfg.credit_addr <= CREDIT_ADDR_RST;
            r_cfg.magic_token <= MAGIC_TOKEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---------------- framing ----------------
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               in_xfer;
    logic               out_xfer;
    logic               last_byte;
    logic               shift;
    t_sample            sample;
    t_result            dec;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_xfer  = o_out_valid && i_out_ready;
    assign last_byte = (r_count == COUNT_W'(BUF_BYTES));
    // the mask byte is decoded, never stored
    assign shift     = in_xfer && !last_byte;

    always_comb begin
        n_count = r_count;
        if (in_xfer) begin
            n_count = last_byte ? '0 : r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // chain of byte cells: new byte enters at the top, oldest sits in cell 0
    for (genvar g = 0; g < BUF_BYTES; g++) begin : g_cell
        logic [7:0] cell_in;
        if (g == BUF_BYTES - 1) begin : g_top
            assign cell_in = i_byte_in;
        end else begin : g_mid
            assign cell_in = sample[g + 1];
        end
        tsmd_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_data  (cell_in),
            .o_data  (sample[g])
        );
    end

    tsmd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_xfer && last_byte),
        .i_mask   (i_byte_in),
        .i_sample (sample),
        .i_cfg    (r_cfg),
        .o_result (dec)
    );

    // ---------------- output register ----------------
    logic        r_out_valid;
    logic        n_out_valid;
    t_event_kind r_kind;
    logic [31:0] r_payload;
    logic [2:0]  r_out_count;
    logic        load;

    // accept while empty or while the held event leaves this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign load       = dec.valid;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (out_xfer) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind      <= dec.kind;
            r_payload   <= dec.payload;
            r_out_count <= dec.count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_kind;
    assign o_payload       = r_payload;
    assign o_payload_count = r_out_count;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(BUF_BYTES))
        else $error("byte counter beyond record length");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && last_byte) |=> (r_count == '0))
        else $error("counter did not wrap after mask byte");

    a_event_only_on_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec.valid) |-> (in_xfer && last_byte))
        else $error("event raised outside a record end");

    a_side_events_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_kind != EV_MAILBOX) |-> (r_payload == '0 && r_out_count == '0))
        else $error("resync or credit event carries payload");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_count <= 3'd4))
        else $error("payload count above four");
`endif
endmodule
`default_nettype wire

// ----- rtl/tsmd_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsmd_cell
// One byte cell of the sample chain: hold a byte, load from the neighbor.
// ----------------------------------------------------------------------------
module tsmd_cell (
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_data,
    output logic      [7:0] o_data
);
    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = i_shift ? i_data : r_data;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

// ----- rtl/tsmd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsmd_decode
// Record decoder: classify a completed record and keep the mailbox word.
// ----------------------------------------------------------------------------
module tsmd_decode (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_mask,
    input  wire tsmd_pkg::t_sample i_sample,
    input  wire tsmd_pkg::t_cfg    i_cfg,
    output tsmd_pkg::t_result      o_result
);
    import tsmd_pkg::*;

    t_word8            r_inbox;
    t_word8            n_inbox;
    t_word8            d;
    t_word8            w;
    logic [7:0]        mask_rot;
    logic [ADDR_W-1:0] addr;
    logic              is_resync;
    logic              is_inbox;
    logic              is_credit;
    logic              lo_we;
    logic              hi_we;
    logic [2:0]        len;

    always_comb begin
        d         = unrotate_data(i_sample);
        addr      = {i_sample[3], i_sample[2], i_sample[1]};
        mask_rot  = {i_mask[5:0], i_mask[7:6]};
        is_resync = (i_sample[0] != HDR_CREDIT) && (addr == i_cfg.resync_addr);
        is_inbox  = (i_sample[0] != HDR_CREDIT) && !is_resync &&
                    (addr == i_cfg.inbox_addr);
        is_credit = (i_sample[0] == HDR_CREDIT) && (addr == i_cfg.credit_addr);
        lo_we     = (mask_rot[3:0] == 4'h0);
        hi_we     = (mask_rot[7:4] == 4'h0);

        // merge the masked halves into the word before testing it
        w = r_inbox;
        if (lo_we) begin
            w[3:0] = d[3:0];
        end
        if (hi_we) begin
            w[7:4] = d[7:4];
        end
        len = w[0][2:0];

        n_inbox  = r_inbox;
        o_result = '0;
        o_result.kind = EV_MAILBOX;
        if (i_fire) begin
            if (is_resync) begin
                if (token_ok(d, i_cfg.magic_token)) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = EV_RESYNC;
                end
            end else if (is_inbox) begin
                n_inbox = w;
                if (hi_we) begin
                    n_inbox = '0;
                    if (token_ok(w, i_cfg.magic_token)) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = EV_MAILBOX;
                        o_result.count = len;
                        for (int k = 0; k < 4; k++) begin
                            if (3'(k) < len) begin
                                o_result.payload[8*k +: 8] = w[4 + k];
                            end
                        end
                    end
                end
            end else if (is_credit) begin
                if (d[3:0] == 32'h0) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = EV_CREDIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inbox <= '0;
        end else begin
            r_inbox <= n_inbox;
        end
    end
endmodule
`default_nettype wire
